// ===== hdl/mfr_pkg.sv =====
// Shared types, codes and constants for the multichannel PWM fade ramp.
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

  // Build-time defaults
  localparam int NUM_CHANNELS_DEF = 8;

  // Field widths
  localparam int LVL_W  = 16;
  localparam int DUTY_W = 17;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int DIV_W  = 32;

  localparam logic [DUTY_W-1:0] FULL_Q16 = 17'h10000;

  // Action codes of a request
  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MAX_LEVEL    = 3'd0;
  localparam logic [IDX_W-1:0] REG_FADE_STEPS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_FADE_ENABLE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_INVERT_MASK  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PRESENT_MASK = 3'd4;

  // Register reset values
  localparam logic [15:0] MAX_LEVEL_RST    = 16'd1000;
  localparam logic [15:0] FADE_STEPS_RST   = 16'd32;
  localparam logic        FADE_ENABLE_RST  = 1'b1;
  localparam logic [7:0]  INVERT_MASK_RST  = 8'h00;
  localparam logic [7:0]  PRESENT_MASK_RST = 8'hFF;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        channel;
    logic [DUTY_W-1:0] duty_q16;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        out_channel;
    logic [LVL_W-1:0]  level;
    logic [DUTY_W-1:0] duty_out_q16;
    logic              status;
    logic              last;
  } out_rsp_t;

  // Sequencer to output buffer
  typedef struct packed {
    logic put;
    logic fin;
  } ob_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ABSENT,
    S_MUL,
    S_SET_CHK,
    S_SET_DIV,
    S_ACK,
    S_RD,
    S_RD_DIV,
    S_WALK,
    S_FLUSH
  } mfr_state_t;

endpackage

`default_nettype wire

// ===== hdl/mfr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mfr_div import mfr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [15:0]      divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic [CNT_W-1:0] cnt;
  logic [15:0]      rem;
  logic [15:0]      dvs;
  logic [DIV_W-1:0] dq;
  logic [16:0]      rem_sh;
  logic             ge;

  // trial subtract
  assign rem_sh   = {rem, dq[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      rem <= ge ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
      dq  <= {dq[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mfr_out_buf.sv =====
// Result buffer: holds one result back so the final one can be marked last.
`timescale 1ns / 1ps
`default_nettype none

module mfr_out_buf import mfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ob_ctrl_t ctrl,
  input  wire out_rsp_t rsp_in,
  output logic          can_take,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_rsp_t      out_rsp
);

  logic     pend_valid;
  out_rsp_t pend;
  out_rsp_t pend_in;
  out_rsp_t out_in;
  logic     can_push;
  logic     push;
  logic     take;

  assign can_push = !out_valid || out_ready;
  assign can_take = !pend_valid || can_push;
  assign take     = ctrl.put && can_take;
  // held result moves out when a newer one arrives or the request ends
  assign push     = can_take && pend_valid && (ctrl.put || ctrl.fin);

  // last flag: cleared on entry, set on the way out when the request ends
  always_comb begin
    pend_in      = rsp_in;
    pend_in.last = 1'b0;
    out_in       = pend;
    out_in.last  = ctrl.fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        pend_valid <= 1'b1;
      end else if (ctrl.fin && can_take) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_rsp <= out_in;
    end
    if (take) begin
      pend <= pend_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/multichannel_pwm_fade_ramp.sv =====
// Multichannel PWM fade ramp: sequencer, channel state and configuration.
//
// Each request is handled alone; in_ready is high only while the block is idle.
// A set waits on the shared restoring divider when fading needs a step division,
// and a read always does; the divider produces one of 32 quotient bits per cycle.
// A set with no division and a request for an absent channel do not use it.
// Init and tick walk the channels one per cycle while the result side takes
// their writes. Any request may take longer while the result side holds off
// out_ready. Registers are written through cfg_we, cfg_index and cfg_data and
// must only be changed while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_pwm_fade_ramp import mfr_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_req_t          in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_rsp_t              out_rsp,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  // Configuration
  logic [15:0] max_level;
  logic [15:0] fade_steps;
  logic        fade_enable;
  logic [7:0]  invert_mask;
  logic [7:0]  present_mask;

  // Channel state
  logic [LVL_W-1:0] cur_lvl  [NUM_CHANNELS];
  logic [LVL_W-1:0] goal_lvl [NUM_CHANNELS];
  logic [LVL_W-1:0] step_lvl [NUM_CHANNELS];
  logic [LVL_W-1:0] ticks    [NUM_CHANNELS];

  // Request context
  mfr_state_t        state, state_next;
  logic [1:0]        act_r;
  logic [3:0]        ch_r;
  logic [DUTY_W-1:0] duty_r;
  logic [LVL_W-1:0]  goal_r;
  logic [CH_W-1:0]   idx;

  logic [NUM_CHANNELS-1:0] chan_on;
  logic [NUM_CHANNELS-1:0] chan_inv;
  logic                    in_on;
  logic                    accept;
  logic [CH_W-1:0]         sel;
  logic                    sel_on;
  logic                    sel_inv;
  logic [LVL_W-1:0]        sel_cur;
  logic [LVL_W-1:0]        sel_goal;
  logic [LVL_W-1:0]        sel_step;
  logic [LVL_W-1:0]        sel_ticks;
  logic [15:0]             eff_max;
  logic [15:0]             eff_fs;

  // Datapath
  logic [DUTY_W-1:0] dsat;
  logic [DUTY_W-1:0] dval;
  logic [32:0]       prod;
  logic [LVL_W-1:0]  diff;
  logic [LVL_W-1:0]  lvl0;
  logic [LVL_W-1:0]  t1;
  logic [LVL_W-1:0]  nl;
  logic [DUTY_W-1:0] qs;
  logic [DUTY_W-1:0] rd_duty;

  // Sequencer outputs
  logic             upd_cur, upd_goal, upd_step, upd_ticks;
  logic [LVL_W-1:0] cur_val, step_val, ticks_val;
  logic             walk_adv;
  ob_ctrl_t         ob_ctrl;
  out_rsp_t         rsp;
  logic             ob_ok;

  // Divider
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [15:0]      div_divisor;
  logic             div_busy;
  logic [DIV_W-1:0] div_q;

  // Per-channel mask bits; only the first eight channels have mask bits
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_mask
    if (i < 8) begin : g_on
      assign chan_on[i]  = present_mask[i];
      assign chan_inv[i] = invert_mask[i];
    end else begin : g_off
      assign chan_on[i]  = 1'b0;
      assign chan_inv[i] = 1'b0;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_on    = ({1'b0, in_req.channel} < 5'(NUM_CHANNELS)) &&
                    chan_on[in_req.channel[CH_W-1:0]];

  assign eff_max = (max_level == 16'd0) ? 16'd1 : max_level;
  assign eff_fs  = (fade_steps == 16'd0) ? 16'd1 : fade_steps;

  // Single channel port: walk counter or the request's channel
  assign sel       = (state == S_WALK) ? idx : ch_r[CH_W-1:0];
  assign sel_on    = chan_on[sel];
  assign sel_inv   = chan_inv[sel];
  assign sel_cur   = cur_lvl[sel];
  assign sel_goal  = goal_lvl[sel];
  assign sel_step  = step_lvl[sel];
  assign sel_ticks = ticks[sel];

  // Duty to level: saturate, invert, scale
  assign dsat = (duty_r > FULL_Q16) ? FULL_Q16 : duty_r;
  assign dval = sel_inv ? (FULL_Q16 - dsat) : dsat;
  assign prod = 33'(eff_max) * 33'(dval);

  assign diff = (goal_r >= sel_cur) ? (goal_r - sel_cur) : (sel_cur - goal_r);
  assign lvl0 = sel_inv ? eff_max : '0;
  assign t1   = sel_ticks - 1'b1;
  assign nl   = (t1 == '0) ? sel_goal :
                (sel_goal > sel_cur) ? (sel_cur + sel_step) : (sel_cur - sel_step);

  // Level to duty: clamp the quotient to full, then invert
  assign qs      = (div_q > DIV_W'(FULL_Q16)) ? FULL_Q16 : div_q[DUTY_W-1:0];
  assign rd_duty = sel_inv ? (FULL_Q16 - qs) : qs;

  // Next state and actions
  always_comb begin
    state_next   = state;
    upd_cur      = 1'b0;
    upd_goal     = 1'b0;
    upd_step     = 1'b0;
    upd_ticks    = 1'b0;
    cur_val      = sel_cur;
    step_val     = sel_step;
    ticks_val    = sel_ticks;
    walk_adv     = 1'b0;
    ob_ctrl      = '0;
    rsp          = '0;
    rsp.out_channel = ch_r;
    div_start    = 1'b0;
    div_dividend = {16'd0, diff};
    div_divisor  = eff_fs;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_req.action == ACT_INIT || in_req.action == ACT_TICK) begin
            state_next = S_WALK;
          end else if (!in_on) begin
            state_next = S_ABSENT;
          end else if (in_req.action == ACT_SET) begin
            state_next = S_MUL;
          end else begin
            state_next = S_RD;
          end
        end
      end

      S_ABSENT: begin
        ob_ctrl.put = 1'b1;
        rsp.kind    = (act_r == ACT_SET) ? KIND_ACK : KIND_READ;
        rsp.status  = 1'b1;
        if (ob_ok) begin
          state_next = S_FLUSH;
        end
      end

      S_MUL: begin
        state_next = S_SET_CHK;
      end

      S_SET_CHK: begin
        if (fade_enable) begin
          upd_goal  = 1'b1;
          upd_ticks = 1'b1;
          if (diff >= eff_fs) begin
            ticks_val  = eff_fs;
            div_start  = 1'b1;
            state_next = S_SET_DIV;
          end else if (diff != '0) begin
            ticks_val  = diff;
            upd_step   = 1'b1;
            step_val   = 16'd1;
            state_next = S_ACK;
          end else begin
            ticks_val  = '0;
            state_next = S_ACK;
          end
        end else begin
          // immediate set; a write only when the level moves
          rsp.kind  = KIND_WRITE;
          rsp.level = goal_r;
          if (goal_r != sel_cur) begin
            ob_ctrl.put = 1'b1;
          end
          if (goal_r == sel_cur || ob_ok) begin
            upd_goal   = 1'b1;
            upd_ticks  = 1'b1;
            ticks_val  = '0;
            upd_cur    = 1'b1;
            cur_val    = goal_r;
            state_next = S_ACK;
          end
        end
      end

      S_SET_DIV: begin
        if (!div_busy) begin
          upd_step   = 1'b1;
          step_val   = div_q[LVL_W-1:0];
          state_next = S_ACK;
        end
      end

      S_ACK: begin
        ob_ctrl.put = 1'b1;
        rsp.kind    = KIND_ACK;
        rsp.level   = goal_r;
        if (ob_ok) begin
          state_next = S_FLUSH;
        end
      end

      S_RD: begin
        div_start    = 1'b1;
        div_dividend = {sel_cur, 16'd0};
        div_divisor  = eff_max;
        state_next   = S_RD_DIV;
      end

      S_RD_DIV: begin
        rsp.kind         = KIND_READ;
        rsp.level        = sel_cur;
        rsp.duty_out_q16 = rd_duty;
        if (!div_busy) begin
          ob_ctrl.put = 1'b1;
          if (ob_ok) begin
            state_next = S_FLUSH;
          end
        end
      end

      S_WALK: begin
        rsp.kind        = KIND_WRITE;
        rsp.out_channel = 4'(idx);
        walk_adv        = 1'b1;
        if (act_r == ACT_INIT) begin
          rsp.level = lvl0;
          if (sel_on) begin
            if (lvl0 != sel_cur) begin
              ob_ctrl.put = 1'b1;
              walk_adv    = ob_ok;
            end
            upd_ticks = walk_adv;
            ticks_val = '0;
            upd_cur   = walk_adv;
            cur_val   = lvl0;
          end
        end else begin
          rsp.level = nl;
          if (sel_on && sel_ticks != '0) begin
            if (nl != sel_cur) begin
              ob_ctrl.put = 1'b1;
              walk_adv    = ob_ok;
            end
            upd_ticks = walk_adv;
            ticks_val = t1;
            upd_cur   = walk_adv;
            cur_val   = nl;
          end
        end
        if (walk_adv && idx == LAST_CH) begin
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        ob_ctrl.fin = 1'b1;
        if (ob_ok) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request context
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_req.action;
      ch_r   <= in_req.channel;
      duty_r <= in_req.duty_q16;
      idx    <= '0;
    end else if (state == S_WALK && walk_adv) begin
      idx <= idx + 1'b1;
    end
    if (state == S_MUL) begin
      goal_r <= prod[31:16];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_level    <= MAX_LEVEL_RST;
      fade_steps   <= FADE_STEPS_RST;
      fade_enable  <= FADE_ENABLE_RST;
      invert_mask  <= INVERT_MASK_RST;
      present_mask <= PRESENT_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LEVEL:    max_level    <= cfg_data;
        REG_FADE_STEPS:   fade_steps   <= cfg_data;
        REG_FADE_ENABLE:  fade_enable  <= cfg_data[0];
        REG_INVERT_MASK:  invert_mask  <= cfg_data[7:0];
        REG_PRESENT_MASK: present_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Channel state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cur_lvl[i]  <= '0;
        goal_lvl[i] <= '0;
        step_lvl[i] <= '0;
        ticks[i]    <= '0;
      end
    end else begin
      if (upd_cur) begin
        cur_lvl[sel] <= cur_val;
      end
      if (upd_goal) begin
        goal_lvl[sel] <= goal_r;
      end
      if (upd_step) begin
        step_lvl[sel] <= step_val;
      end
      if (upd_ticks) begin
        ticks[sel] <= ticks_val;
      end
    end
  end

  mfr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  mfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ob_ctrl),
    .rsp_in    (rsp),
    .can_take  (ob_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

// ===== sim/multichannel_pwm_fade_ramp_tb.sv =====
// Self-checking testbench for the multichannel PWM fade ramp: predictor, stimulus, checks.
`timescale 1ns / 1ps

module multichannel_pwm_fade_ramp_tb import mfr_pkg::*;;

  // Limit lies well above the long hold-off, the longest request and random stalls
  localparam int STALL_LIMIT   = 4000;
  // A tick or init with nothing to report still walks all channels
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int CHUNK_ITEMS   = 27;

  // Tracks channel levels, ramps and registers; holds the reports still due
  class channel_ramp_tracker;
    logic [15:0]      max_level;
    logic [15:0]      fade_steps;
    logic             fade_on;
    logic [7:0]       invert_mask;
    logic [7:0]       present_mask;
    logic [LVL_W-1:0] cur_lvl[NUM_CHANNELS_DEF];
    logic [LVL_W-1:0] goal_lvl[NUM_CHANNELS_DEF];
    logic [LVL_W-1:0] step_lvl[NUM_CHANNELS_DEF];
    logic [LVL_W-1:0] ticks_left[NUM_CHANNELS_DEF];
    out_rsp_t         due_reports[$];
    out_rsp_t         batch[$];
    int               mismatches;

    function new();
      max_level    = MAX_LEVEL_RST;
      fade_steps   = FADE_STEPS_RST;
      fade_on      = FADE_ENABLE_RST;
      invert_mask  = INVERT_MASK_RST;
      present_mask = PRESENT_MASK_RST;
      foreach (cur_lvl[c]) begin
        cur_lvl[c]    = '0;
        goal_lvl[c]   = '0;
        step_lvl[c]   = '0;
        ticks_left[c] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MAX_LEVEL:    max_level    = val;
        REG_FADE_STEPS:   fade_steps   = val;
        REG_FADE_ENABLE:  fade_on      = val[0];
        REG_INVERT_MASK:  invert_mask  = val[7:0];
        REG_PRESENT_MASK: present_mask = val[7:0];
        default: ;
      endcase
    endfunction

    function int reports_due();
      return due_reports.size();
    endfunction

    function bit chan_on(int c);
      if (c >= NUM_CHANNELS_DEF || c >= 8) return 1'b0;
      return present_mask[c];
    endfunction

    function bit chan_inv(int c);
      if (c >= 8) return 1'b0;
      return invert_mask[c];
    endfunction

    // Zero full scale counts as one
    function longint unsigned full_scale();
      return (max_level == 0) ? 1 : max_level;
    endfunction

    function logic [LVL_W-1:0] duty_level(bit inv, logic [DUTY_W-1:0] duty);
      longint unsigned d;
      logic [63:0]     prod;
      d = (duty > FULL_Q16) ? FULL_Q16 : duty;
      if (inv) d = FULL_Q16 - d;
      prod = (full_scale() * d) >> 16;
      return prod[15:0];
    endfunction

    function logic [DUTY_W-1:0] level_duty(bit inv, logic [LVL_W-1:0] lvl);
      logic [63:0] q;
      q = lvl;
      q = (q << 16) / full_scale();
      if (q > FULL_Q16) q = FULL_Q16;
      if (inv) q = FULL_Q16 - q;
      return q[16:0];
    endfunction

    function void emit(logic [1:0] k, int c, logic [LVL_W-1:0] l,
                       logic [DUTY_W-1:0] d, logic s);
      out_rsp_t r;
      r.kind         = k;
      r.out_channel  = c[3:0];
      r.level        = l;
      r.duty_out_q16 = d;
      r.status       = s;
      r.last         = 1'b0;
      batch.push_back(r);
    endfunction

    // A level write goes out only on a real change
    function void move_to(int c, logic [LVL_W-1:0] lvl);
      if (lvl != cur_lvl[c]) begin
        cur_lvl[c] = lvl;
        emit(KIND_WRITE, c, lvl, '0, 1'b0);
      end
    endfunction

    function void take_request(in_req_t req);
      int               ch;
      logic [LVL_W-1:0] goal;
      logic [LVL_W-1:0] nl;
      int unsigned      change;
      int unsigned      fs;
      out_rsp_t         r;
      batch.delete();
      ch = req.channel;
      case (req.action)
        ACT_INIT: begin
          for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
            if (chan_on(c)) begin
              ticks_left[c] = '0;
              move_to(c, duty_level(chan_inv(c), '0));
            end
          end
        end
        ACT_SET: begin
          if (!chan_on(ch)) begin
            emit(KIND_ACK, ch, '0, '0, 1'b1);
          end else begin
            goal = duty_level(chan_inv(ch), req.duty_q16);
            ticks_left[ch] = '0;
            goal_lvl[ch]   = goal;
            if (fade_on) begin
              change = (goal > cur_lvl[ch]) ? goal - cur_lvl[ch] : cur_lvl[ch] - goal;
              fs = (fade_steps == 0) ? 1 : fade_steps;
              if (change >= fs) begin
                ticks_left[ch] = fs[15:0];
                step_lvl[ch]   = 16'(change / fs);
              end else if (change > 0) begin
                ticks_left[ch] = change[15:0];
                step_lvl[ch]   = 16'd1;
              end
            end else begin
              move_to(ch, goal);
            end
            emit(KIND_ACK, ch, goal, '0, 1'b0);
          end
        end
        ACT_TICK: begin
          for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
            if (chan_on(c) && ticks_left[c] != 0) begin
              ticks_left[c] = ticks_left[c] - 16'd1;
              if (ticks_left[c] != 0) begin
                if (goal_lvl[c] > cur_lvl[c]) nl = cur_lvl[c] + step_lvl[c];
                else nl = cur_lvl[c] - step_lvl[c];
              end else begin
                nl = goal_lvl[c];
              end
              move_to(c, nl);
            end
          end
        end
        default: begin
          if (!chan_on(ch)) emit(KIND_READ, ch, '0, '0, 1'b1);
          else emit(KIND_READ, ch, cur_lvl[ch], level_duty(chan_inv(ch), cur_lvl[ch]), 1'b0);
        end
      endcase
      if (batch.size() > 0) begin
        r = batch.pop_back();
        r.last = 1'b1;
        batch.push_back(r);
      end
      foreach (batch[i]) due_reports.push_back(batch[i]);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(out_rsp_t got);
      out_rsp_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result with none due: expected nothing, actual %h", $time, got);
        return;
      end
      want = due_reports.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("out_channel", want.out_channel, got.out_channel);
      compare_field("level", want.level, got.level);
      compare_field("duty_out_q16", want.duty_out_q16, got.duty_out_q16);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_req_t          in_req    = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_rsp_t         out_rsp;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  channel_ramp_tracker board = new();
  int send_idle    = 27;
  int recv_idle    = 87;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  multichannel_pwm_fade_ramp DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Offer one request, with a random gap first, and wait for acceptance
  task automatic send_req(in_req_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    board.take_request(req);
  endtask

  task automatic send(logic [1:0] act, logic [3:0] ch, logic [DUTY_W-1:0] duty);
    in_req_t req;
    req.action   = act;
    req.channel  = ch;
    req.duty_q16 = duty;
    send_req(req);
  endtask

  // Let every due report arrive, then let a silent tick or init run out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.reports_due() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
  endtask

  task automatic random_config();
    logic [15:0] lvl;
    logic [15:0] steps;
    case ($urandom_range(5))
      0: lvl = 16'd0;
      1: lvl = 16'd1;
      2: lvl = 16'hFFFF;
      default: lvl = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(5))
      0: steps = 16'd0;
      1: steps = 16'hFFFF;
      default: steps = 16'($urandom_range(1, 12));
    endcase
    write_reg(REG_MAX_LEVEL, lvl);
    write_reg(REG_FADE_STEPS, steps);
    write_reg(REG_FADE_ENABLE, ($urandom_range(3) != 0) ? 16'd1 : 16'd0);
    write_reg(REG_INVERT_MASK, 16'($urandom_range(255)));
    write_reg(REG_PRESENT_MASK, $urandom_range(1) ? 16'h00FF : 16'($urandom_range(255)));
  endtask

  // Mostly sets and ticks on live channels; a few stray and raw requests
  function automatic in_req_t random_request();
    in_req_t req;
    int      pick;
    req.action   = 2'($urandom_range(3));
    req.channel  = 4'($urandom_range(15));
    req.duty_q16 = 17'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) begin
      req.action = ACT_INIT;
    end else if (pick < 40) begin
      req.action = ACT_TICK;
    end else if (pick < 75) begin
      req.action = ACT_SET;
      if ($urandom_range(99) < 85) req.channel = 4'($urandom_range(NUM_CHANNELS_DEF - 1));
      case ($urandom_range(4))
        0: req.duty_q16 = '0;
        1: req.duty_q16 = FULL_Q16;
        2: req.duty_q16 = 17'($urandom);
        default: req.duty_q16 = 17'($urandom_range(65536));
      endcase
    end else if (pick < 92) begin
      req.action = ACT_READ;
    end
    return req;
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_report(out_rsp);
  end

  // Watchdog: too long with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: reads, ramps up from zero, saturated duty, tiny change
    send(ACT_READ, 4'd0, '0);
    send(ACT_READ, 4'd15, '0);
    send(ACT_SET, 4'd0, FULL_Q16);
    send(ACT_SET, 4'd1, 17'h1FFFF);
    send(ACT_SET, 4'd2, '0);
    send(ACT_SET, 4'd3, 17'd100);
    send(ACT_TICK, 4'd0, '0);
    send(ACT_TICK, 4'd0, '0);
    send(ACT_READ, 4'd0, '0);
    send(ACT_SET, 4'd12, 17'd500);
    send(ACT_INIT, 4'd0, '0);
    send(ACT_TICK, 4'd0, '0);
    send(ACT_SET, 4'd5, FULL_Q16);
    settle();

    // Fading off: pending ramp still advances, sets jump at once
    write_reg(REG_FADE_ENABLE, 16'd0);
    send(ACT_TICK, 4'd0, '0);
    send(ACT_SET, 4'd6, 17'd32768);
    send(ACT_SET, 4'd6, 17'd32768);
    send(ACT_READ, 4'd6, '0);
    settle();

    // Zero full scale and zero steps, sparse channels, inverted ones
    write_reg(REG_MAX_LEVEL, 16'd0);
    write_reg(REG_FADE_STEPS, 16'd0);
    write_reg(REG_FADE_ENABLE, 16'd1);
    write_reg(REG_INVERT_MASK, 16'h00F0);
    write_reg(REG_PRESENT_MASK, 16'h005A);
    send(ACT_INIT, 4'd0, '0);
    send(ACT_SET, 4'd0, FULL_Q16);
    send(ACT_SET, 4'd4, FULL_Q16);
    send(ACT_TICK, 4'd0, '0);
    send(ACT_READ, 4'd4, '0);
    send(ACT_READ, 4'd3, '0);
    settle();

    // Largest scale and step count, all inverted
    write_reg(REG_MAX_LEVEL, 16'hFFFF);
    write_reg(REG_FADE_STEPS, 16'hFFFF);
    write_reg(REG_INVERT_MASK, 16'h00FF);
    write_reg(REG_PRESENT_MASK, 16'h00FF);
    send(ACT_SET, 4'd7, '0);
    send(ACT_TICK, 4'd0, '0);
    send(ACT_READ, 4'd7, '0);

    // Random requests under three idling patterns, new settings per chunk
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 27; recv_idle = 87; end
        1: begin send_idle = 87; recv_idle = 27; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        settle();
        random_config();
        if (ph == 2 && chunk == 1) hold_request = 1'b1;
        repeat (CHUNK_ITEMS) send_req(random_request());
      end
    end
    settle();

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
